// ===== rtl/core/hcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// hcpu_pkg: shared types and constants of the 8-bit Harvard CPU core
// Holds the instruction field codes, the request and response payloads and
// the data RAM geometry.
// ----------------------------------------------------------------------------
package hcpu_pkg;

   // Data RAM geometry.
   localparam int RAM_ADDR_BITS = 15;
   localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;

   // Page mask applied to the program counter by a short jump.
   localparam logic [15:0] PC_PAGE_MASK = 16'hff00;

   // Operation field, opcode bits 7..5.
   typedef enum logic [2:0] {
      OP_LD  = 3'd0,
      OP_AND = 3'd1,
      OP_OR  = 3'd2,
      OP_XOR = 3'd3,
      OP_ADD = 3'd4,
      OP_SUB = 3'd5,
      OP_ST  = 3'd6,
      OP_JMP = 3'd7
   } op_type;

   // Addressing mode field, opcode bits 4..2.
   typedef enum logic [2:0] {
      MODE_D_AC      = 3'd0,
      MODE_X_AC      = 3'd1,
      MODE_YD_AC     = 3'd2,
      MODE_YX_AC     = 3'd3,
      MODE_D_X       = 3'd4,
      MODE_D_Y       = 3'd5,
      MODE_D_OUT     = 3'd6,
      MODE_YXINC_OUT = 3'd7
   } mode_type;

   // Bus source field, opcode bits 1..0.
   typedef enum logic [1:0] {
      BUS_D   = 2'd0,
      BUS_RAM = 2'd1,
      BUS_AC  = 2'd2,
      BUS_IN  = 2'd3
   } bus_type;

   // Destination of an ALU result.
   typedef enum logic [2:0] {
      DEST_NONE,
      DEST_AC,
      DEST_X,
      DEST_Y,
      DEST_OUT
   } dest_type;

   // One clock tick of the machine.
   typedef struct packed {
      logic [7:0] fetched_opcode;
      logic [7:0] fetched_operand;
      logic [7:0] input_port;
      logic [7:0] floating_bus_value;
   } req_type;

   // Machine state after a tick.
   typedef struct packed {
      logic [15:0] fetch_address;
      logic [7:0]  output_port;
      logic [7:0]  accumulator_view;
      logic [7:0]  index_x_view;
      logic [7:0]  index_y_view;
   } rsp_type;

endpackage

// ===== rtl/core/hcpu_if.sv =====
// ----------------------------------------------------------------------------
// hcpu_if: valid/ready channels of the CPU core
// One interface carries tick requests, the other carries state responses.
// ----------------------------------------------------------------------------
interface hcpu_req_if import hcpu_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hcpu_rsp_if import hcpu_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/harvard_8bit_cpu_core.sv =====
// ----------------------------------------------------------------------------
// harvard_8bit_cpu_core: 8-bit Harvard CPU executing one instruction per tick
// Executes the latched instruction against AC, X, Y, OUT and a data RAM,
// latches the new program word and reports the next fetch address.
// ----------------------------------------------------------------------------
// Every request is one machine clock tick and yields exactly one response.
// The core takes one request per cycle while its response buffer has room:
// the data RAM read of the next instruction is issued on the cycle its
// program word is accepted, so the registered read data are ready when it
// executes; a store to that same address in the same cycle is forwarded. A
// two-entry response buffer keeps requests flowing while a response waits.
// After reset the data RAM is cleared one byte a cycle, over every address
// up to RAM_DEPTH - 1; no request is accepted until that pass ends.
module harvard_8bit_cpu_core import hcpu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hcpu_req_if.sink   req,
   hcpu_rsp_if.source rsp
);

   localparam logic [RAM_ADDR_BITS-1:0] RAM_LAST = '1;

   // Architectural registers.
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  ir_ff;
   logic [7:0]  d_ff;
   logic [7:0]  ac_ff, ac_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [7:0]  outreg_ff, outreg_in;

   // Data RAM and its read path.
   logic [7:0]               ram_mem [RAM_DEPTH];
   logic [7:0]               rd_data_ff;
   logic                     byp_ff;
   logic [7:0]               byp_data_ff;
   logic [RAM_ADDR_BITS-1:0] rd_addr;
   logic [RAM_ADDR_BITS-1:0] exec_addr;
   logic                     ram_we;
   logic [RAM_ADDR_BITS-1:0] ram_waddr;
   logic [7:0]               ram_wdata;
   logic [7:0]               ram_q;

   // Clearing pass after reset.
   logic                     clr_busy_ff;
   logic [RAM_ADDR_BITS-1:0] clr_addr_ff;

   // Response buffer.
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   rsp_type rsp_new;

   // Decode of the executing instruction.
   op_type   op;
   mode_type mode;
   bus_type  src;
   op_type   nxt_op;
   mode_type nxt_mode;
   logic     is_store;
   logic     is_jump;
   dest_type dest;
   logic     bump_x;
   logic [7:0] bus;
   logic [7:0] alu;
   logic     take_branch;
   logic     accept;
   logic     out_take;

   // Data address of an instruction; jumps address D on page zero.
   function automatic logic [RAM_ADDR_BITS-1:0] calc_addr(
      input logic [2:0] f_mode,
      input logic       f_jump,
      input logic [7:0] f_d,
      input logic [7:0] f_x,
      input logic [7:0] f_y
   );
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [15:0] full;
      lo = f_d;
      hi = 8'h00;
      if (!f_jump) begin
         unique case (mode_type'(f_mode))
            MODE_X_AC:      lo = f_x;
            MODE_YD_AC:     hi = f_y;
            MODE_YX_AC, MODE_YXINC_OUT: begin
               lo = f_x;
               hi = f_y;
            end
            default:        lo = f_d;
         endcase
      end
      full = {hi, lo};
      return full[RAM_ADDR_BITS-1:0];
   endfunction

   assign accept   = req.valid && req.ready;
   assign out_take = out_valid_ff && rsp.ready;
   assign req.ready = !skid_valid_ff && !clr_busy_ff;

   assign op       = op_type'(ir_ff[7:5]);
   assign mode     = mode_type'(ir_ff[4:2]);
   assign src      = bus_type'(ir_ff[1:0]);
   assign is_store = (op == OP_ST);
   assign is_jump  = (op == OP_JMP);

   // Destination selection and X post-increment.
   always_comb begin
      dest   = DEST_NONE;
      bump_x = 1'b0;
      if (!is_jump) begin
         unique case (mode)
            MODE_D_AC, MODE_X_AC, MODE_YD_AC, MODE_YX_AC: dest = DEST_AC;
            MODE_D_X:   dest = DEST_X;
            MODE_D_Y:   dest = DEST_Y;
            MODE_D_OUT: dest = DEST_OUT;
            MODE_YXINC_OUT: begin
               dest   = DEST_OUT;
               bump_x = 1'b1;
            end
            default:    dest = DEST_NONE;
         endcase
         if (is_store && dest != DEST_X && dest != DEST_Y) begin
            dest = DEST_NONE;
         end
      end
   end

   assign exec_addr = calc_addr(ir_ff[4:2], is_jump, d_ff, x_ff, y_ff);

   // RAM data, with a same-cycle store forwarded.
   assign ram_q = byp_ff ? byp_data_ff : rd_data_ff;

   // Bus source; a store never drives the RAM onto the bus.
   always_comb begin
      case (src)
         BUS_D:   bus = d_ff;
         BUS_RAM: bus = is_store ? req.payload.floating_bus_value : ram_q;
         BUS_AC:  bus = ac_ff;
         default: bus = req.payload.input_port;
      endcase
   end

   // ALU.
   always_comb begin
      case (op)
         OP_LD:   alu = bus;
         OP_AND:  alu = ac_ff & bus;
         OP_OR:   alu = ac_ff | bus;
         OP_XOR:  alu = ac_ff ^ bus;
         OP_ADD:  alu = ac_ff + bus;
         OP_SUB:  alu = ac_ff - bus;
         OP_ST:   alu = ac_ff;
         default: alu = 8'h00 - ac_ff;
      endcase
   end

   // Register write-back.
   always_comb begin
      ac_in     = ac_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      outreg_in = outreg_ff;
      case (dest)
         DEST_AC:  ac_in     = alu;
         DEST_X:   x_in      = alu;
         DEST_Y:   y_in      = alu;
         DEST_OUT: outreg_in = alu;
         default:  ;
      endcase
      if (bump_x) begin
         x_in = x_ff + 8'd1;
      end
   end

   // Branch condition: bit 0 greater, bit 1 less, bit 2 equal to zero.
   always_comb begin
      if (ac_ff == 8'h00) begin
         take_branch = ir_ff[4];
      end else if (ac_ff[7]) begin
         take_branch = ir_ff[3];
      end else begin
         take_branch = ir_ff[2];
      end
   end

   // Next program counter.
   always_comb begin
      pc_in = pc_ff + 16'd1;
      if (is_jump) begin
         if (mode == MODE_D_AC) begin
            pc_in = {y_ff, bus};
         end else if (take_branch) begin
            pc_in = (pc_ff & PC_PAGE_MASK) | {8'h00, bus};
         end
      end
   end

   // Read address of the instruction being latched, using updated X and Y.
   assign nxt_op   = op_type'(req.payload.fetched_opcode[7:5]);
   assign nxt_mode = mode_type'(req.payload.fetched_opcode[4:2]);
   assign rd_addr  = calc_addr(nxt_mode, nxt_op == OP_JMP,
                               req.payload.fetched_operand, x_in, y_in);

   // RAM write port: clearing pass or store.
   assign ram_we    = clr_busy_ff || (accept && is_store);
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : exec_addr;
   assign ram_wdata = clr_busy_ff ? 8'h00 : bus;

   // Data RAM, read-first.
   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[ram_waddr] <= ram_wdata;
      end
      if (accept) begin
         rd_data_ff <= ram_mem[rd_addr];
      end
   end

   // Forwarding of a store that hits the address being read.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (accept) begin
         byp_ff <= is_store && (exec_addr == rd_addr);
      end
      if (accept) begin
         byp_data_ff <= bus;
      end
   end

   // Clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + RAM_ADDR_BITS'(1);
         if (clr_addr_ff == RAM_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         ir_ff     <= '0;
         d_ff      <= '0;
         ac_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         outreg_ff <= '0;
      end else if (accept) begin
         pc_ff     <= pc_in;
         ir_ff     <= req.payload.fetched_opcode;
         d_ff      <= req.payload.fetched_operand;
         ac_ff     <= ac_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         outreg_ff <= outreg_in;
      end
   end

   // Response of this tick.
   always_comb begin
      rsp_new.fetch_address    = pc_in;
      rsp_new.output_port      = outreg_in;
      rsp_new.accumulator_view = ac_in;
      rsp_new.index_x_view     = x_in;
      rsp_new.index_y_view     = y_in;
   end

   // Two-entry response buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_data_ff <= rsp_new;
         end else begin
            skid_data_ff <= rsp_new;
         end
      end else if (out_take && skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_data_ff;

endmodule

// ===== tb/sv/tb_harvard_8bit_cpu_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_harvard_8bit_cpu_core: self-checking bench for the 8-bit Harvard CPU core
// Each request is one machine tick. A shadow of the core executes the same
// instruction stream and checks every response field by field. A short
// directed program is followed by random programs under changing
// back-pressure.
// ----------------------------------------------------------------------------
module tb_harvard_8bit_cpu_core import hcpu_pkg::*; ();

   // Cycles without any handshake before the run is declared hung. The RAM
   // clearing pass after reset is the longest quiet stretch.
   localparam int HANG_LIMIT   = 3 * RAM_DEPTH + 10000;
   localparam int RANDOM_TICKS = 130;

   // Shadow copy of the machine state and the queue of predicted responses.
   class core_shadow;
      bit [15:0] pc;
      bit [7:0]  ir;
      bit [7:0]  dr;
      bit [7:0]  ac;
      bit [7:0]  ix;
      bit [7:0]  iy;
      bit [7:0]  out_reg;
      bit [7:0]  data_mem [RAM_DEPTH];
      rsp_type   expected_states[$];
      int unsigned mismatches;

      // Executes the latched instruction, latches the new word and queues
      // the resulting machine state.
      function void note_tick(req_type t);
         op_type      op;
         mode_type    mode;
         bus_type     src;
         dest_type    dest;
         bit [7:0]    lo;
         bit [7:0]    hi;
         bit [7:0]    bus;
         bit [7:0]    alu;
         bit [7:0]    old_x;
         bit [7:0]    old_y;
         bit [7:0]    old_ac;
         bit [15:0]   old_pc;
         int unsigned addr;
         int unsigned cond;
         bit          bump_x;
         rsp_type     st;

         op     = op_type'(ir[7:5]);
         mode   = mode_type'(ir[4:2]);
         src    = bus_type'(ir[1:0]);
         lo     = dr;
         hi     = 8'h00;
         dest   = DEST_NONE;
         bump_x = 1'b0;

         // Addressing mode picks the destination and the data address.
         if (op != OP_JMP) begin
            case (mode)
               MODE_D_AC: dest = DEST_AC;
               MODE_X_AC: begin
                  dest = DEST_AC;
                  lo   = ix;
               end
               MODE_YD_AC: begin
                  dest = DEST_AC;
                  hi   = iy;
               end
               MODE_YX_AC: begin
                  dest = DEST_AC;
                  lo   = ix;
                  hi   = iy;
               end
               MODE_D_X: dest = DEST_X;
               MODE_D_Y: dest = DEST_Y;
               MODE_D_OUT: dest = DEST_OUT;
               default: begin
                  dest   = DEST_OUT;
                  lo     = ix;
                  hi     = iy;
                  bump_x = 1'b1;
               end
            endcase
            if (op == OP_ST && dest != DEST_X && dest != DEST_Y)
               dest = DEST_NONE;
         end
         addr = {hi, lo} & (RAM_DEPTH - 1);

         // A store never drives RAM onto the bus, so it sees the floating value.
         case (src)
            BUS_D:   bus = dr;
            BUS_RAM: bus = (op == OP_ST) ? t.floating_bus_value : data_mem[addr];
            BUS_AC:  bus = ac;
            default: bus = t.input_port;
         endcase
         if (op == OP_ST)
            data_mem[addr] = bus;

         case (op)
            OP_LD:   alu = bus;
            OP_AND:  alu = ac & bus;
            OP_OR:   alu = ac | bus;
            OP_XOR:  alu = ac ^ bus;
            OP_ADD:  alu = ac + bus;
            OP_SUB:  alu = ac - bus;
            OP_ST:   alu = ac;
            default: alu = 8'h00 - ac;
         endcase

         old_x  = ix;
         old_y  = iy;
         old_ac = ac;
         old_pc = pc;

         case (dest)
            DEST_AC:  ac = alu;
            DEST_X:   ix = alu;
            DEST_Y:   iy = alu;
            DEST_OUT: out_reg = alu;
            default: ;
         endcase
         if (bump_x)
            ix = old_x + 8'd1;

         // Mode bits of a conditional jump select gt, lt and eq on signed AC.
         pc = old_pc + 16'd1;
         if (op == OP_JMP) begin
            if (mode != MODE_D_AC) begin
               cond = old_ac[7] + ((old_ac == 8'h00) ? 2 : 0);
               if (mode[cond])
                  pc = (old_pc & PC_PAGE_MASK) | {8'h00, bus};
            end else begin
               pc = {old_y, bus};
            end
         end

         ir = t.fetched_opcode;
         dr = t.fetched_operand;

         st.fetch_address    = pc;
         st.output_port      = out_reg;
         st.accumulator_view = ac;
         st.index_x_view     = ix;
         st.index_y_view     = iy;
         expected_states.push_back(st);
      endfunction

      // Compares one response with the oldest predicted state.
      function void check_state(rsp_type got);
         rsp_type exp_st;

         if (expected_states.size() == 0) begin
            $error("unexpected response: fetch_address %h", got.fetch_address);
            mismatches++;
            return;
         end
         exp_st = expected_states.pop_front();
         if (got.fetch_address !== exp_st.fetch_address) begin
            $error("fetch_address: expected %h, got %h",
                   exp_st.fetch_address, got.fetch_address);
            mismatches++;
         end
         if (got.output_port !== exp_st.output_port) begin
            $error("output_port: expected %h, got %h",
                   exp_st.output_port, got.output_port);
            mismatches++;
         end
         if (got.accumulator_view !== exp_st.accumulator_view) begin
            $error("accumulator_view: expected %h, got %h",
                   exp_st.accumulator_view, got.accumulator_view);
            mismatches++;
         end
         if (got.index_x_view !== exp_st.index_x_view) begin
            $error("index_x_view: expected %h, got %h",
                   exp_st.index_x_view, got.index_x_view);
            mismatches++;
         end
         if (got.index_y_view !== exp_st.index_y_view) begin
            $error("index_y_view: expected %h, got %h",
                   exp_st.index_y_view, got.index_y_view);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   hcpu_req_if req_ch ();
   hcpu_rsp_if rsp_ch ();

   core_shadow  shadow;
   int unsigned sender_idle_pct;
   int unsigned sink_stall_pct;

   harvard_8bit_cpu_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response side: random stalls and checking of every accepted response.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            shadow.check_state(rsp_ch.payload);
         if (req_ch.valid && req_ch.ready)
            shadow.note_tick(req_ch.payload);
      end
   end

   // Hang detection: ends the run when no request or response moves for too
   // long.
   initial begin : hang_watch
      int unsigned quiet_cycles;

      quiet_cycles = 0;
      while (quiet_cycles < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Builds one tick from its instruction fields and side inputs.
   function automatic req_type make_tick(op_type op, mode_type mode, bus_type src,
                                         logic [7:0] d, logic [7:0] port,
                                         logic [7:0] flt);
      req_type t;

      t.fetched_opcode     = {op, mode, src};
      t.fetched_operand    = d;
      t.input_port         = port;
      t.floating_bus_value = flt;
      return t;
   endfunction

   // Presents one request after a random idle gap and waits for acceptance.
   task automatic send_tick(input req_type t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= t;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Holds off requests until every predicted response has been seen.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (shadow.expected_states.size() != 0)
         @(posedge clock);
   endtask

   // Operand biased toward a few addresses so loads find earlier stores.
   function automatic logic [7:0] pick_operand();
      logic [7:0] hot [6];

      hot = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
      if ($urandom_range(2) == 0)
         return 8'($urandom);
      return hot[$urandom_range(5)];
   endfunction

   // Random program: mostly free instructions, plus store/load pairs that hit
   // the same data address.
   task automatic run_random(input int unsigned count);
      int unsigned sent;
      logic [7:0]  d;
      mode_type    mode;

      sent = 0;
      while (sent < count) begin
         if ($urandom_range(3) == 0) begin
            d    = pick_operand();
            mode = mode_type'($urandom_range(3));
            send_tick(make_tick(OP_ST, mode, bus_type'($urandom_range(3)), d,
                                8'($urandom), 8'($urandom)));
            send_tick(make_tick(op_type'($urandom_range(5)), mode, BUS_RAM, d,
                                8'($urandom), 8'($urandom)));
            sent += 2;
         end else begin
            send_tick(make_tick(op_type'($urandom_range(7)),
                                mode_type'($urandom_range(7)),
                                bus_type'($urandom_range(3)), pick_operand(),
                                8'($urandom), 8'($urandom)));
            sent++;
         end
      end
   endtask

   // Main sequence.
   initial begin
      shadow          = new();
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed program: the first tick runs the cleared instruction, a load
      // of zero into AC.
      send_tick(make_tick(OP_LD,  MODE_D_Y,       BUS_D,   8'hff, 8'hff, 8'h00));
      send_tick(make_tick(OP_LD,  MODE_D_X,       BUS_D,   8'hff, 8'h00, 8'hff));
      // Store through [Y,X++] from the floating bus at the wrapped top address.
      send_tick(make_tick(OP_ST,  MODE_YXINC_OUT, BUS_RAM, 8'h00, 8'hff, 8'h5a));
      send_tick(make_tick(OP_LD,  MODE_D_X,       BUS_D,   8'hff, 8'hff, 8'ha5));
      send_tick(make_tick(OP_LD,  MODE_YX_AC,     BUS_RAM, 8'h00, 8'h00, 8'h00));
      send_tick(make_tick(OP_ADD, MODE_D_AC,      BUS_D,   8'hff, 8'h00, 8'hff));
      send_tick(make_tick(OP_SUB, MODE_X_AC,      BUS_IN,  8'h00, 8'h00, 8'h00));
      send_tick(make_tick(OP_AND, MODE_YD_AC,     BUS_AC,  8'h80, 8'hff, 8'hff));
      send_tick(make_tick(OP_OR,  MODE_D_AC,      BUS_IN,  8'h00, 8'h80, 8'h00));
      send_tick(make_tick(OP_XOR, MODE_D_AC,      BUS_D,   8'hff, 8'h7f, 8'hff));
      send_tick(make_tick(OP_ST,  MODE_D_X,       BUS_AC,  8'h10, 8'hff, 8'h00));
      send_tick(make_tick(OP_ST,  MODE_D_Y,       BUS_D,   8'h80, 8'h00, 8'hff));
      send_tick(make_tick(OP_LD,  MODE_D_AC,      BUS_RAM, 8'h80, 8'hff, 8'h00));
      // The store to Y above loaded Y from AC (zero), so this reads address 0x0010.
      send_tick(make_tick(OP_LD,  MODE_YD_AC,     BUS_RAM, 8'h10, 8'h00, 8'hff));
      send_tick(make_tick(OP_LD,  MODE_D_OUT,     BUS_D,   8'hff, 8'hff, 8'h00));
      send_tick(make_tick(OP_LD,  MODE_YXINC_OUT, BUS_IN,  8'h00, 8'hc0, 8'h00));
      send_tick(make_tick(OP_JMP, MODE_D_AC,      BUS_D,   8'h34, 8'hff, 8'hff));
      send_tick(make_tick(OP_LD,  MODE_D_AC,      BUS_D,   8'h00, 8'h00, 8'h00));
      send_tick(make_tick(OP_JMP, MODE_D_X,       BUS_D,   8'h77, 8'hff, 8'h00));
      send_tick(make_tick(OP_LD,  MODE_D_AC,      BUS_D,   8'h80, 8'h00, 8'hff));
      send_tick(make_tick(OP_JMP, MODE_YD_AC,     BUS_AC,  8'h00, 8'hff, 8'h00));
      send_tick(make_tick(OP_JMP, MODE_D_OUT,     BUS_IN,  8'h00, 8'h3c, 8'h00));
      send_tick(make_tick(OP_LD,  MODE_D_AC,      BUS_D,   8'h01, 8'hff, 8'hff));
      send_tick(make_tick(OP_JMP, MODE_YXINC_OUT, BUS_IN,  8'h00, 8'h55, 8'h00));
      send_tick(make_tick(OP_JMP, MODE_X_AC,      BUS_RAM, 8'h10, 8'hff, 8'h00));

      // Random programs under changing back-pressure.
      run_random(RANDOM_TICKS);
      sender_idle_pct = 64;
      run_random(RANDOM_TICKS);
      wait_for_drain();
      sender_idle_pct = 0;
      sink_stall_pct  = 64;
      run_random(RANDOM_TICKS);
      sender_idle_pct = 33;
      sink_stall_pct  = 33;
      run_random(RANDOM_TICKS);
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      run_random(RANDOM_TICKS);

      // Let the last responses arrive, then a short tail for strays.
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.expected_states.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
